[design/pphg_pkg.sv]
// Shared types, codes and the microcode program for the probe packet generator.
// No dependencies.
package pphg_pkg;

    localparam int PC_W = 6;

    localparam logic [1:0] OP_ICMP = 2'd0;
    localparam logic [1:0] OP_UDP  = 2'd1;
    localparam logic [1:0] OP_ARP  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [0:0] CFG_LOCAL_MAC = 1'b0;
    localparam logic [0:0] CFG_IP_IDENT  = 1'b1;

    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] ICMP_TOTAL = 16'd28;
    localparam logic [15:0] FILL_FULL  = 16'h4242;
    localparam logic [15:0] FILL_HALF  = 16'h4200;

    localparam logic [PC_W-1:0] ADDR_IP   = 6'd0;
    localparam logic [PC_W-1:0] ADDR_FILL = 6'd22;
    localparam logic [PC_W-1:0] ADDR_ICMP = 6'd23;
    localparam logic [PC_W-1:0] ADDR_ARP  = 6'd30;

    typedef enum logic [4:0] {
        SRC_IMM, SRC_TOTAL, SRC_IDENT, SRC_TTLPROTO, SRC_SRC_HI, SRC_SRC_LO,
        SRC_DST_HI, SRC_DST_LO, SRC_SUM, SRC_PORT_HI, SRC_PORT_LO, SRC_UDPLEN,
        SRC_BCMAC, SRC_MAC_HI, SRC_MAC_MID, SRC_MAC_LO, SRC_FILL
    } t_src;

    typedef enum logic [1:0] {
        A_LOAD, A_ADD, A_EMIT
    } t_act;

    typedef enum logic [1:0] {
        J_NEXT, J_KIND, J_UNTIL, J_END
    } t_jmp;

    typedef struct packed {
        logic            en;
        t_src            src;
        t_act            act;
        t_jmp            jmp;
        logic [15:0]     imm;
        logic [PC_W-1:0] target;
    } t_uop;

    typedef struct packed {
        logic is_icmp;
        logic at_last;
    } t_dp_status;

    function automatic t_uop mk(t_src s, t_act a, t_jmp j, logic [15:0] imm,
                                logic [PC_W-1:0] tgt);
        t_uop u;
        u.en     = 1'b1;
        u.src    = s;
        u.act    = a;
        u.jmp    = j;
        u.imm    = imm;
        u.target = tgt;
        return u;
    endfunction

    function automatic t_uop em(t_src s);
        return mk(s, A_EMIT, J_NEXT, 16'h0000, ADDR_IP);
    endfunction

    function automatic t_uop ek(logic [15:0] imm);
        return mk(SRC_IMM, A_EMIT, J_NEXT, imm, ADDR_IP);
    endfunction

    function automatic t_uop rom_word(logic [PC_W-1:0] a);
        t_uop u;
        case (a)
            // IPv4 checksum accumulation
            6'd0:  u = mk(SRC_IMM, A_LOAD, J_NEXT, 16'h4500, ADDR_IP);
            6'd1:  u = mk(SRC_TOTAL, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            6'd2:  u = mk(SRC_IDENT, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            6'd3:  u = mk(SRC_TTLPROTO, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            6'd4:  u = mk(SRC_SRC_HI, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            6'd5:  u = mk(SRC_SRC_LO, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            6'd6:  u = mk(SRC_DST_HI, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            6'd7:  u = mk(SRC_DST_LO, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            // IPv4 header
            6'd8:  u = ek(16'h4500);
            6'd9:  u = em(SRC_TOTAL);
            6'd10: u = em(SRC_IDENT);
            6'd11: u = ek(16'h0000);
            6'd12: u = em(SRC_TTLPROTO);
            6'd13: u = em(SRC_SUM);
            6'd14: u = em(SRC_SRC_HI);
            6'd15: u = em(SRC_SRC_LO);
            6'd16: u = em(SRC_DST_HI);
            6'd17: u = mk(SRC_DST_LO, A_EMIT, J_KIND, 16'h0000, ADDR_ICMP);
            // UDP header and filler
            6'd18: u = em(SRC_PORT_HI);
            6'd19: u = em(SRC_PORT_LO);
            6'd20: u = em(SRC_UDPLEN);
            6'd21: u = mk(SRC_IMM, A_EMIT, J_UNTIL, 16'h0000, ADDR_FILL);
            6'd22: u = mk(SRC_FILL, A_EMIT, J_UNTIL, 16'h0000, ADDR_FILL);
            // ICMP echo
            6'd23: u = mk(SRC_IMM, A_LOAD, J_NEXT, 16'h0800, ADDR_IP);
            6'd24: u = mk(SRC_PORT_HI, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            6'd25: u = mk(SRC_PORT_LO, A_ADD, J_NEXT, 16'h0000, ADDR_IP);
            6'd26: u = ek(16'h0800);
            6'd27: u = em(SRC_SUM);
            6'd28: u = em(SRC_PORT_HI);
            6'd29: u = mk(SRC_PORT_LO, A_EMIT, J_END, 16'h0000, ADDR_IP);
            // ARP request
            6'd30: u = em(SRC_BCMAC);
            6'd31: u = em(SRC_BCMAC);
            6'd32: u = em(SRC_BCMAC);
            6'd33: u = em(SRC_MAC_HI);
            6'd34: u = em(SRC_MAC_MID);
            6'd35: u = em(SRC_MAC_LO);
            6'd36: u = ek(16'h0806);
            6'd37: u = ek(16'h0001);
            6'd38: u = ek(16'h0800);
            6'd39: u = ek(16'h0604);
            6'd40: u = ek(16'h0001);
            6'd41: u = em(SRC_MAC_HI);
            6'd42: u = em(SRC_MAC_MID);
            6'd43: u = em(SRC_MAC_LO);
            6'd44: u = em(SRC_SRC_HI);
            6'd45: u = em(SRC_SRC_LO);
            6'd46: u = ek(16'h0000);
            6'd47: u = ek(16'h0000);
            6'd48: u = ek(16'h0000);
            6'd49: u = em(SRC_DST_HI);
            6'd50: u = mk(SRC_DST_LO, A_EMIT, J_END, 16'h0000, ADDR_IP);
            default: u = mk(SRC_IMM, A_LOAD, J_END, 16'h0000, ADDR_IP);
        endcase
        return u;
    endfunction

endpackage

[design/pphg_sequencer.sv]
// Step counter and control store: fetches one control word per cycle and resolves jumps.
// Depends on pphg_pkg.
module pphg_sequencer
    import pphg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [1:0] i_op,
    input  t_dp_status i_status,
    output t_uop       o_uop,
    output logic       o_busy
);

    logic            r_run;
    logic [PC_W-1:0] r_pc;
    t_uop            w_rom;

    assign w_rom = rom_word(r_pc);

    always_comb begin
        o_uop    = w_rom;
        o_uop.en = r_run;
    end

    assign o_busy = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= ADDR_IP;
        end else if (i_load) begin
            r_run <= 1'b1;
            r_pc  <= (i_op == OP_ARP) ? ADDR_ARP : ADDR_IP;
        end else if (r_run) begin
            case (w_rom.jmp)
                J_NEXT: begin
                    r_pc <= r_pc + PC_W'(1);
                end
                J_KIND: begin
                    r_pc <= i_status.is_icmp ? w_rom.target : r_pc + PC_W'(1);
                end
                J_UNTIL: begin
                    if (i_status.at_last) begin
                        r_run <= 1'b0;
                    end else begin
                        r_pc <= w_rom.target;
                    end
                end
                J_END: begin
                    r_run <= 1'b0;
                end
                default: begin
                    r_run <= 1'b0;
                end
            endcase
        end
    end

endmodule

[design/pphg_datapath.sv]
// Held request fields, checksum accumulator, word select and registered result beat.
// Depends on pphg_pkg.
module pphg_datapath
    import pphg_pkg::*;
#(
    parameter int UDP_PACKET_BYTES = 60
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [7:0]  i_ttl,
    input  logic [15:0] i_echo_id,
    input  logic [15:0] i_echo_seq,
    input  logic [15:0] i_udp_sport,
    input  logic [15:0] i_udp_dport,
    input  logic        i_broadcast,
    input  logic [47:0] i_local_mac,
    input  logic [15:0] i_ip_ident,
    input  t_uop        i_uop,
    output t_dp_status  o_status,
    output logic        o_strobe,
    output logic [15:0] o_data_word,
    output logic [4:0]  o_word_offset,
    output logic        o_last
);

    localparam int UDP_WORDS = (UDP_PACKET_BYTES + 1) / 2;
    localparam logic [4:0]  LAST_IDX = 5'(UDP_WORDS - 1);
    localparam logic [15:0] UDP_TOTAL = 16'(UDP_PACKET_BYTES);
    localparam logic [15:0] UDP_LEN = 16'(UDP_PACKET_BYTES - 20);
    localparam logic UDP_ODD = (UDP_PACKET_BYTES % 2) == 1;

    logic [1:0]  r_kind;
    logic [63:0] r_addr;
    logic [31:0] r_ports;
    logic [8:0]  r_ttl_bc;
    logic [19:0] r_acc;
    logic [4:0]  r_word_index;

    logic        w_icmp;
    logic        w_at_last;
    logic [16:0] w_fold1;
    logic [16:0] w_fold2;
    logic [15:0] w_sum;
    logic [15:0] w_word;
    logic        w_emit;
    logic        w_last;

    assign w_icmp    = (r_kind == OP_ICMP);
    assign w_at_last = (r_word_index == LAST_IDX);
    assign o_status  = '{is_icmp: w_icmp, at_last: w_at_last};

    assign w_fold1 = {13'd0, r_acc[19:16]} + {1'b0, r_acc[15:0]};
    assign w_fold2 = {1'b0, w_fold1[15:0]} + {16'd0, w_fold1[16]};
    assign w_sum   = ~w_fold2[15:0];

    always_comb begin
        case (i_uop.src)
            SRC_IMM:      w_word = i_uop.imm;
            SRC_TOTAL:    w_word = w_icmp ? ICMP_TOTAL : UDP_TOTAL;
            SRC_IDENT:    w_word = i_ip_ident;
            SRC_TTLPROTO: w_word = {r_ttl_bc[7:0], w_icmp ? PROTO_ICMP : PROTO_UDP};
            SRC_SRC_HI:   w_word = r_addr[63:48];
            SRC_SRC_LO:   w_word = r_addr[47:32];
            SRC_DST_HI:   w_word = r_addr[31:16];
            SRC_DST_LO:   w_word = r_addr[15:0];
            SRC_SUM:      w_word = w_sum;
            SRC_PORT_HI:  w_word = r_ports[31:16];
            SRC_PORT_LO:  w_word = r_ports[15:0];
            SRC_UDPLEN:   w_word = UDP_LEN;
            SRC_BCMAC:    w_word = {16{r_ttl_bc[8]}};
            SRC_MAC_HI:   w_word = i_local_mac[47:32];
            SRC_MAC_MID:  w_word = i_local_mac[31:16];
            SRC_MAC_LO:   w_word = i_local_mac[15:0];
            SRC_FILL:     w_word = (UDP_ODD && w_at_last) ? FILL_HALF : FILL_FULL;
            default:      w_word = 16'h0000;
        endcase
    end

    assign w_emit = i_uop.en && (i_uop.act == A_EMIT);
    assign w_last = (i_uop.jmp == J_END) || ((i_uop.jmp == J_UNTIL) && w_at_last);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addr   <= {i_src_ip, i_dst_ip};
            r_ttl_bc <= {i_broadcast, i_ttl};
            r_ports  <= (i_op == OP_ICMP) ? {i_echo_id, i_echo_seq} : {i_udp_sport, i_udp_dport};
        end
        if (i_uop.en && (i_uop.act == A_LOAD)) begin
            r_acc <= {4'd0, w_word};
        end else if (i_uop.en && (i_uop.act == A_ADD)) begin
            r_acc <= r_acc + {4'd0, w_word};
        end
        o_data_word   <= w_word;
        o_word_offset <= r_word_index;
        o_last        <= w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind       <= OP_ICMP;
            r_word_index <= 5'd0;
            o_strobe     <= 1'b0;
        end else begin
            o_strobe <= w_emit;
            if (i_load) begin
                r_kind       <= i_op;
                r_word_index <= 5'd0;
            end else if (w_emit) begin
                r_word_index <= r_word_index + 5'd1;
            end
        end
    end

endmodule

[design/probe_packet_header_generator.sv]
// Top level of the probe packet generator: configuration registers and unit wiring.
// Depends on pphg_pkg, pphg_sequencer and pphg_datapath.

// A request is taken when start is high and busy is low; op 3 is ignored and produces
// nothing. The packet leaves as 16-bit network-order words, one per o_strobe beat,
// with its index in o_word_offset and o_last on the final word. The receiver cannot
// stall, so every beat must be captured in its cycle. The microcode program sets the
// order: an IPv4 packet first sums the header words (one add per cycle), then emits
// the header at one word per cycle. ICMP echo has a gap without beats between the IPv4
// and ICMP headers while the ICMP checksum is summed; the UDP probe emits filler words
// up to word (UDP_PACKET_BYTES+1)/2 - 1; the ARP request has no gaps and its words
// begin at once, while IPv4 words wait for the header sum.
// Configuration writes are taken at once and must only be made while busy is low.
module probe_packet_header_generator
    import pphg_pkg::*;
#(
    parameter int UDP_PACKET_BYTES = 60
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [7:0]  i_ttl,
    input  logic [15:0] i_echo_id,
    input  logic [15:0] i_echo_seq,
    input  logic [15:0] i_udp_sport,
    input  logic [15:0] i_udp_dport,
    input  logic        i_broadcast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output logic        o_strobe,
    output logic [15:0] o_data_word,
    output logic [4:0]  o_word_offset,
    output logic        o_last
);

    logic [47:0] r_local_mac;
    logic [15:0] r_ip_ident;
    logic        w_load;
    t_uop        w_uop;
    t_dp_status  w_status;

    assign o_cfg_ready = 1'b1;
    assign w_load = start && !busy && (i_op != OP_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= 48'd0;
            r_ip_ident  <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOCAL_MAC: r_local_mac <= i_cfg_data;
                CFG_IP_IDENT:  r_ip_ident  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    pphg_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_op     (i_op),
        .i_status (w_status),
        .o_uop    (w_uop),
        .o_busy   (busy)
    );

    pphg_datapath #(
        .UDP_PACKET_BYTES (UDP_PACKET_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_op          (i_op),
        .i_src_ip      (i_src_ip),
        .i_dst_ip      (i_dst_ip),
        .i_ttl         (i_ttl),
        .i_echo_id     (i_echo_id),
        .i_echo_seq    (i_echo_seq),
        .i_udp_sport   (i_udp_sport),
        .i_udp_dport   (i_udp_dport),
        .i_broadcast   (i_broadcast),
        .i_local_mac   (r_local_mac),
        .i_ip_ident    (r_ip_ident),
        .i_uop         (w_uop),
        .o_status      (w_status),
        .o_strobe      (o_strobe),
        .o_data_word   (o_data_word),
        .o_word_offset (o_word_offset),
        .o_last        (o_last)
    );

endmodule
